### design/rc4_pkg.sv
`timescale 1ns / 1ps

package rc4_pkg;

    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 8;
    localparam int KEY_CNT_W  = 9;
    localparam int BOX_DEPTH  = 256;
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(BOX_DEPTH - 1);

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [KEY_CNT_W-1:0] t_key_cnt;

    typedef struct packed {
        logic capture;
        logic key_write;
        logic key_clear;
        logic sched_init;
        logic sched_rd;
        logic sched_j;
        logic sched_w1;
        logic sched_w2;
        logic copy_rd;
        logic idx_clear;
        logic ks_ri;
        logic ks_rj;
        logic ks_w1;
        logic ks_w2;
        logic out_load;
        logic out_hold;
    } t_cmd;

    typedef struct packed {
        logic n_last;
        logic out_free;
    } t_sts;

endpackage

### design/rc4_ctrl.sv
`timescale 1ns / 1ps

module rc4_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_mode,
    input  logic          i_last,
    input  rc4_pkg::t_sts i_sts,
    output rc4_pkg::t_cmd o_cmd,
    output logic          o_stall
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_KEY,
        S_SINIT,
        S_SRD,
        S_SJ,
        S_SW1,
        S_SW2,
        S_COPY,
        S_RI,
        S_RJ,
        S_W1,
        S_W2,
        S_HOLD
    } t_state;

    t_state r_state;
    logic   r_mode;
    logic   r_last;
    logic   r_restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= 1'b0;
            r_last    <= 1'b0;
            r_restart <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode <= i_mode;
                        r_last <= i_last;
                        if (!i_mode) begin
                            r_state <= S_KEY;
                        end else if (r_restart) begin
                            r_state <= S_COPY;
                        end else begin
                            r_state <= S_RI;
                        end
                    end
                end
                S_KEY: begin
                    r_state <= r_last ? S_SINIT : S_IDLE;
                end
                S_SINIT: begin
                    if (i_sts.n_last) begin
                        r_state <= S_SRD;
                    end
                end
                S_SRD: r_state <= S_SJ;
                S_SJ:  r_state <= S_SW1;
                S_SW1: r_state <= S_SW2;
                S_SW2: begin
                    if (i_sts.n_last) begin
                        r_restart <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_state <= S_SRD;
                    end
                end
                S_COPY: begin
                    if (i_sts.n_last) begin
                        r_restart <= 1'b0;
                        r_state   <= S_RI;
                    end
                end
                S_RI: r_state <= S_RJ;
                S_RJ: r_state <= S_W1;
                S_W1: r_state <= S_W2;
                S_W2: begin
                    if (r_last) begin
                        r_restart <= 1'b1;
                    end
                    r_state <= i_sts.out_free ? S_IDLE : S_HOLD;
                end
                S_HOLD: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:  o_cmd.capture    = i_valid;
            S_KEY:   o_cmd.key_write  = 1'b1;
            S_SINIT: o_cmd.sched_init = 1'b1;
            S_SRD:   o_cmd.sched_rd   = 1'b1;
            S_SJ:    o_cmd.sched_j    = 1'b1;
            S_SW1:   o_cmd.sched_w1   = 1'b1;
            S_SW2: begin
                o_cmd.sched_w2  = 1'b1;
                o_cmd.key_clear = i_sts.n_last;
            end
            S_COPY: begin
                o_cmd.copy_rd   = 1'b1;
                o_cmd.idx_clear = 1'b1;
            end
            S_RI: o_cmd.ks_ri = 1'b1;
            S_RJ: o_cmd.ks_rj = 1'b1;
            S_W1: o_cmd.ks_w1 = 1'b1;
            S_W2: begin
                o_cmd.ks_w2    = 1'b1;
                o_cmd.out_load = i_sts.out_free;
            end
            S_HOLD: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.out_hold = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_stall = (r_state != S_IDLE) || !i_rst_n;

    a_sched_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.key_clear |=> r_restart)
        else $error("key schedule ended without a pending restart");

    a_copy_only_on_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.copy_rd |-> r_restart)
        else $error("box reload without a pending restart");

    a_step_after_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ks_ri |-> (!r_restart && r_mode))
        else $error("keystream step with a reload still pending");

endmodule

### design/rc4_dp.sv
`timescale 1ns / 1ps

module rc4_dp #(
    parameter int MAX_KEY_BYTES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rc4_pkg::t_cmd     i_cmd,
    input  rc4_pkg::t_byte    i_data_byte,
    input  logic              i_stall,
    output rc4_pkg::t_sts     o_sts,
    output logic              o_valid,
    output rc4_pkg::t_byte    o_out_byte
);

    rc4_pkg::t_byte r_key_store [rc4_pkg::BOX_DEPTH];
    rc4_pkg::t_byte r_saved_box [rc4_pkg::BOX_DEPTH];
    rc4_pkg::t_byte r_live_box  [rc4_pkg::BOX_DEPTH];

    rc4_pkg::t_byte    r_key_rd;
    rc4_pkg::t_byte    r_saved_rd;
    rc4_pkg::t_byte    r_live_rd;

    rc4_pkg::t_key_cnt r_key_count;
    rc4_pkg::t_addr    r_n;
    rc4_pkg::t_addr    r_kidx;
    rc4_pkg::t_addr    r_i;
    rc4_pkg::t_addr    r_j;
    logic              r_cp_valid;
    logic              r_out_valid;

    rc4_pkg::t_addr    r_cp_addr;
    rc4_pkg::t_byte    r_byte;
    rc4_pkg::t_byte    r_si;
    rc4_pkg::t_byte    r_sj;
    rc4_pkg::t_byte    r_ks;
    logic              r_t_eq_i;
    logic              r_t_eq_j;
    rc4_pkg::t_byte    r_out_byte;

    rc4_pkg::t_addr    n_i;
    rc4_pkg::t_addr    n_j_ks;
    rc4_pkg::t_addr    n_j_sched;
    rc4_pkg::t_addr    n_kidx;
    rc4_pkg::t_addr    t_addr_sum;
    rc4_pkg::t_key_cnt key_len;
    logic              key_room;
    logic              kidx_wrap;
    rc4_pkg::t_byte    ks;

    logic              saved_we;
    rc4_pkg::t_addr    saved_wa;
    rc4_pkg::t_byte    saved_wd;
    rc4_pkg::t_addr    saved_ra;
    logic              live_we;
    rc4_pkg::t_addr    live_wa;
    rc4_pkg::t_byte    live_wd;
    rc4_pkg::t_addr    live_ra;

    assign n_i        = r_i + 8'd1;
    assign n_j_ks     = r_j + r_live_rd;
    assign n_j_sched  = r_j + r_saved_rd + r_key_rd;
    assign t_addr_sum = r_si + r_live_rd;
    assign key_len    = (r_key_count == '0) ? rc4_pkg::t_key_cnt'(1) : r_key_count;
    assign key_room   = (r_key_count < rc4_pkg::t_key_cnt'(MAX_KEY_BYTES));
    assign kidx_wrap  = (({1'b0, r_kidx} + rc4_pkg::t_key_cnt'(1)) == key_len);
    assign n_kidx     = kidx_wrap ? '0 : r_kidx + 8'd1;
    assign ks         = r_t_eq_j ? r_si : (r_t_eq_i ? r_sj : r_live_rd);

    assign o_sts.n_last   = (r_n == rc4_pkg::ADDR_LAST);
    assign o_sts.out_free = !r_out_valid || !i_stall;

    always_comb begin
        saved_we = 1'b0;
        saved_wa = r_n;
        saved_wd = r_n;
        if (i_cmd.sched_init) begin
            saved_we = 1'b1;
        end else if (i_cmd.sched_w1) begin
            saved_we = 1'b1;
            saved_wd = r_saved_rd;
        end else if (i_cmd.sched_w2) begin
            saved_we = 1'b1;
            saved_wa = r_j;
            saved_wd = r_si;
        end
        saved_ra = i_cmd.sched_j ? n_j_sched : r_n;
    end

    always_comb begin
        live_we = 1'b0;
        live_wa = r_cp_addr;
        live_wd = r_saved_rd;
        if (r_cp_valid) begin
            live_we = 1'b1;
        end else if (i_cmd.ks_w1) begin
            live_we = 1'b1;
            live_wa = r_i;
            live_wd = r_live_rd;
        end else if (i_cmd.ks_w2) begin
            live_we = 1'b1;
            live_wa = r_j;
            live_wd = r_si;
        end
        if (i_cmd.ks_ri) begin
            live_ra = n_i;
        end else if (i_cmd.ks_rj) begin
            live_ra = n_j_ks;
        end else begin
            live_ra = t_addr_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_write && key_room) begin
            r_key_store[r_key_count[rc4_pkg::ADDR_W-1:0]] <= r_byte;
        end
        if (i_cmd.sched_rd) begin
            r_key_rd <= r_key_store[r_kidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (saved_we) begin
            r_saved_box[saved_wa] <= saved_wd;
        end
        r_saved_rd <= r_saved_box[saved_ra];
    end

    always_ff @(posedge i_clk) begin
        if (live_we) begin
            r_live_box[live_wa] <= live_wd;
        end
        r_live_rd <= r_live_box[live_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
            r_n         <= '0;
            r_kidx      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_cp_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cp_valid <= i_cmd.copy_rd;
            if (i_cmd.key_clear) begin
                r_key_count <= '0;
            end else if (i_cmd.key_write && key_room) begin
                r_key_count <= r_key_count + rc4_pkg::t_key_cnt'(1);
            end
            if (i_cmd.sched_init) begin
                r_n    <= r_n + 8'd1;
                r_j    <= '0;
                r_kidx <= '0;
            end
            if (i_cmd.sched_j) begin
                r_j <= n_j_sched;
            end
            if (i_cmd.sched_w2) begin
                r_n    <= r_n + 8'd1;
                r_kidx <= n_kidx;
            end
            if (i_cmd.copy_rd) begin
                r_n <= r_n + 8'd1;
            end
            if (i_cmd.idx_clear) begin
                r_i <= '0;
                r_j <= '0;
            end
            if (i_cmd.ks_ri) begin
                r_i <= n_i;
            end
            if (i_cmd.ks_rj) begin
                r_j <= n_j_ks;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_byte <= i_data_byte;
        end
        r_cp_addr <= r_n;
        if (i_cmd.sched_j) begin
            r_si <= r_saved_rd;
        end
        if (i_cmd.ks_rj) begin
            r_si <= r_live_rd;
        end
        if (i_cmd.ks_w1) begin
            r_sj     <= r_live_rd;
            r_t_eq_i <= (t_addr_sum == r_i);
            r_t_eq_j <= (t_addr_sum == r_j);
        end
        if (i_cmd.ks_w2) begin
            r_ks <= ks;
        end
        if (i_cmd.out_load) begin
            r_out_byte <= r_byte ^ (i_cmd.out_hold ? r_ks : ks);
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;

    a_key_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_count <= rc4_pkg::t_key_cnt'(MAX_KEY_BYTES))
        else $error("key count past its limit");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_stall))
        else $error("result loaded over one still waiting");

    a_copy_write_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_valid |-> !(i_cmd.ks_w1 || i_cmd.ks_w2))
        else $error("box reload write collides with a swap write");

endmodule

### design/rc4_stream_cipher.sv
`timescale 1ns / 1ps

// RC4 stream cipher.
// Input channel (i_valid / o_stall): a request carries i_mode, i_data_byte and
// i_last. Mode 0 stores a key byte; the key byte flagged last runs the key
// schedule. Mode 1 encrypts or decrypts one byte; the byte flagged last ends
// the message and the next message restarts from the scheduled box.
// Output channel (o_valid / i_stall): one o_out_byte per mode 1 request.
// Steps: a key byte is captured and then written to the key store; the last key
// byte adds box initialization and the key schedule (per step: read, index
// update, two writes through the one box write port).
// A data byte takes dependent box reads at i, j and their sum plus the two
// swap writes; the result is registered with the second swap write, or later
// while the output register is not free. The first data byte of a message
// adds a copy of the scheduled box into the working box.
// The output register lets the next request enter while a result waits; if
// a new result is ready while the receiver still stalls, the block holds it
// and keeps o_stall high until the output register frees.
// Reset clears the key length, the indices and o_valid, holds o_stall high
// and marks a restart pending. A key must be loaded before the first data byte.

module rc4_stream_cipher #(
    parameter int MAX_KEY_BYTES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_mode,
    input  logic [7:0] i_data_byte,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte
);

    rc4_pkg::t_cmd cmd;
    rc4_pkg::t_sts sts;

    rc4_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .i_last  (i_last),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    rc4_dp #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_data_byte (i_data_byte),
        .i_stall     (i_stall),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .o_out_byte  (o_out_byte)
    );

endmodule
